### rtl/mcut_pkg.sv
// mcut_pkg: shared types and constants for the multi-channel UART transmitter.
// No dependencies.
`timescale 1ns / 1ps

package mcut_pkg;

  localparam int FUNC_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 4;
  localparam int OUT_BITS = 10;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_QUEUE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP   = 2'd3;

  typedef struct packed {
    logic [OUT_BITS-1:0] lines;
    logic [OUT_BITS-1:0] done;
    logic [OUT_BITS-1:0] act;
    logic                any;
    logic                acc;
  } res_t;

endpackage

### rtl/multi_channel_uart_transmitter.sv
// multi_channel_uart_transmitter: 8N1 transmit channels, one byte FIFO each, stepped by ticks.
// Depends on mcut_pkg.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------------
//  in      | in_valid / in_stall   | func, channel, data_byte
//  out     | out_valid / out_stall | tx_lines, done_flags, active_flags, any_active, accepted
//  cfg     | cfg_wr_en             | cfg_wr_data (channel_count)
//
//  One beat per cycle while in_stall is low: each beat updates all channel state when it is
//  taken, and its status is registered on that edge into the output register, or into the skid entry.
//  Each channel FIFO has a registered read port that always holds the head entry.
//  An output register plus one skid entry; in_stall is high while rst is high or the skid entry is full.
//  rst is synchronous and clears all control state; no clearing pass is needed.

module multi_channel_uart_transmitter
  import mcut_pkg::*;
#(
  parameter int CHANNELS   = 10,
  parameter int FIFO_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [FUNC_W-1:0]   func,
  input  logic [CHAN_W-1:0]   channel,
  input  logic [BYTE_W-1:0]   data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [OUT_BITS-1:0] tx_lines,
  output logic [OUT_BITS-1:0] done_flags,
  output logic [OUT_BITS-1:0] active_flags,
  output logic                any_active,
  output logic                accepted,
  input  logic                cfg_wr_en,
  input  logic [COUNT_W-1:0]  cfg_wr_data
);

  localparam int AW    = $clog2(FIFO_DEPTH);
  localparam int PAD_W = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DATA,
    ST_STOP
  } st_t;

  logic [COUNT_W-1:0] channel_count;
  logic               skid_valid;
  res_t               out_res;
  res_t               skid_res;
  res_t               res_next;

  logic               in_acc;
  logic               out_take;
  logic               tick_acc;
  logic               queue_acc;
  logic               clear_acc;

  logic [CHANNELS-1:0] line_vec;
  logic [CHANNELS-1:0] done_vec;
  logic [CHANNELS-1:0] act_vec;
  logic [CHANNELS-1:0] acc_vec;
  logic [PAD_W-1:0]    line_pad;
  logic [PAD_W-1:0]    done_pad;
  logic [PAD_W-1:0]    act_pad;

  assign in_stall  = rst | skid_valid;
  assign in_acc    = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;
  assign tick_acc  = in_acc && (func == FUNC_TICK);
  assign queue_acc = in_acc && (func == FUNC_QUEUE);
  assign clear_acc = in_acc && (func == FUNC_CLEAR);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    st_t              st, st_next;
    logic             line, line_next;
    logic [2:0]       bit_cnt, bit_cnt_next;
    logic [7:0]       shreg, shreg_next;
    logic             active, active_next;
    logic             done, done_next;
    logic [AW-1:0]    rd_addr, rd_addr_next;
    logic             rd_wrap, rd_wrap_next;
    logic [AW-1:0]    wr_addr, wr_addr_next;
    logic             wr_wrap, wr_wrap_next;
    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       rdata;
    logic             hit, step_en, empty, full, wr_en;

    assign hit     = ({1'b0, channel} == 5'(c));
    assign step_en = ({1'b0, channel_count} > 5'(c));
    assign empty   = (rd_addr == wr_addr) && (rd_wrap == wr_wrap);
    assign full    = (rd_addr == wr_addr) && (rd_wrap != wr_wrap);
    assign wr_en   = queue_acc && hit && !full;

    always_comb begin
      st_next      = st;
      line_next    = line;
      bit_cnt_next = bit_cnt;
      shreg_next   = shreg;
      active_next  = active;
      done_next    = done;
      rd_addr_next = rd_addr;
      rd_wrap_next = rd_wrap;
      wr_addr_next = wr_addr;
      wr_wrap_next = wr_wrap;
      if (tick_acc && active && step_en) begin
        unique case (st)
          ST_IDLE: begin
            if (!empty) begin
              done_next    = 1'b0;
              bit_cnt_next = '0;
              st_next      = ST_START;
              shreg_next   = rdata;
              if (rd_addr == AW'(FIFO_DEPTH - 1)) begin
                rd_addr_next = '0;
                rd_wrap_next = ~rd_wrap;
              end else begin
                rd_addr_next = rd_addr + 1'b1;
              end
            end else begin
              active_next = 1'b0;
              done_next   = 1'b1;
            end
          end
          ST_START: begin
            line_next = 1'b0;
            st_next   = ST_DATA;
          end
          ST_DATA: begin
            line_next    = shreg[0];
            shreg_next   = {1'b0, shreg[7:1]};
            bit_cnt_next = bit_cnt + 1'b1;
            if (bit_cnt == 3'd7) begin
              st_next = ST_STOP;
            end
          end
          ST_STOP: begin
            line_next = 1'b1;
            st_next   = ST_IDLE;
          end
        endcase
      end
      if (queue_acc && hit) begin
        active_next = 1'b1;
        if (!full) begin
          if (wr_addr == AW'(FIFO_DEPTH - 1)) begin
            wr_addr_next = '0;
            wr_wrap_next = ~wr_wrap;
          end else begin
            wr_addr_next = wr_addr + 1'b1;
          end
        end
      end
      if (clear_acc && hit) begin
        done_next = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st      <= ST_IDLE;
        line    <= 1'b1;
        bit_cnt <= '0;
        active  <= 1'b0;
        done    <= 1'b0;
        rd_addr <= '0;
        rd_wrap <= 1'b0;
        wr_addr <= '0;
        wr_wrap <= 1'b0;
      end else begin
        st      <= st_next;
        line    <= line_next;
        bit_cnt <= bit_cnt_next;
        active  <= active_next;
        done    <= done_next;
        rd_addr <= rd_addr_next;
        rd_wrap <= rd_wrap_next;
        wr_addr <= wr_addr_next;
        wr_wrap <= wr_wrap_next;
      end
      shreg <= shreg_next;
    end

    // read port tracks the head entry; a write to the head address is forwarded
    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[wr_addr] <= data_byte;
      end
      if (wr_en && (wr_addr == rd_addr_next)) begin
        rdata <= data_byte;
      end else begin
        rdata <= mem[rd_addr_next];
      end
    end

    assign line_vec[c] = line_next;
    assign done_vec[c] = done_next;
    assign act_vec[c]  = active_next;
    assign acc_vec[c]  = wr_en;
  end

  assign line_pad = PAD_W'(line_vec);
  assign done_pad = PAD_W'(done_vec);
  assign act_pad  = PAD_W'(act_vec);

  always_comb begin
    res_next.lines = line_pad[OUT_BITS-1:0];
    res_next.done  = done_pad[OUT_BITS-1:0];
    res_next.act   = act_pad[OUT_BITS-1:0];
    res_next.any   = |act_vec;
    res_next.acc   = |acc_vec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= '0;
    end else if (cfg_wr_en) begin
      channel_count <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_res    <= skid_res;
          skid_valid <= 1'b0;
        end
      end else if (in_acc) begin
        if (!out_valid || out_take) begin
          out_res   <= res_next;
          out_valid <= 1'b1;
        end else begin
          skid_res   <= res_next;
          skid_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign tx_lines     = out_res.lines;
  assign done_flags   = out_res.done;
  assign active_flags = out_res.act;
  assign any_active   = out_res.any;
  assign accepted     = out_res.acc;

  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_skid_fill : assert property (@(posedge clk) disable iff (rst)
    (in_acc && out_valid && out_stall) |=> skid_valid)
    else $error("beat taken behind a stalled result was not parked");

  a_acc_active : assert property (@(posedge clk) disable iff (rst)
    (in_acc && res_next.acc) |-> res_next.any)
    else $error("stored byte without an active channel");

  a_acc_queue_only : assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func != FUNC_QUEUE)) |-> !res_next.acc)
    else $error("accepted set for a beat that queues no byte");

endmodule
